// ===== sv/vfcm_pkg.sv =====
// vfcm_pkg: shared types and constants for the voxel face culling mesher.
// No dependencies; imported by vfcm_nbr and voxel_face_culling_mesher.
`default_nettype none

package vfcm_pkg;

  localparam int MAX_DIM_DEF = 32;

  localparam int COORD_W = 5;
  localparam int GRID_W  = 6;
  localparam int VAL_W   = 8;
  localparam int CNT_W   = 18;
  localparam int FACES   = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] VERTS_PER_VOXEL = CNT_W'(8);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 2'd2;

  localparam logic [GRID_W-1:0] GRID_RESET = 6'd32;

  // item functions
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_MESH  = 1'b1;

  // read sequence steps; step n (1 <= n <= 6) fetches the neighbour of face n-1
  typedef logic [2:0] step_t;
  localparam step_t STEP_CTR   = 3'd0;
  localparam step_t STEP_LEFT  = 3'd1;
  localparam step_t STEP_RIGHT = 3'd2;
  localparam step_t STEP_TOP   = 3'd3;
  localparam step_t STEP_BOT   = 3'd4;
  localparam step_t STEP_FRONT = 3'd5;
  localparam step_t STEP_REAR  = 3'd6;
  localparam step_t STEP_LAST  = 3'd7;

  // face bit positions
  localparam int FACE_LEFT  = 0;
  localparam int FACE_RIGHT = 1;
  localparam int FACE_TOP   = 2;
  localparam int FACE_BOT   = 3;
  localparam int FACE_FRONT = 4;
  localparam int FACE_REAR  = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  // range check results for the current word
  typedef struct packed {
    logic             err;
    logic [FACES-1:0] edge_hit;
  } nbr_flags_t;

endpackage

`default_nettype wire

// ===== sv/voxel_face_culling_mesher.sv =====
// voxel_face_culling_mesher: top level; volume memory, read sequencer, vertex count.
// Depends on vfcm_pkg and vfcm_nbr.
//
//   channel | direction | words
//   in_     | input     | func, row, column, slice, voxel_value
//   out_    | output    | visible, face_mask, base_vertex, coord_error
//   cfg_    | input     | index, data (grid height, width, depth)
//
// One word at a time. A write word or an out-of-grid word goes from the center
// step straight to the result load; a mesh word first makes seven reads of the
// single-port volume memory (voxel and six neighbours) at one per cycle, then the
// last compare, then the result load. The next word is taken the cycle after the
// result loads.
// rst_n clears control, grid sizes (32) and the vertex count; the volume is not
// cleared. A stalled out_ holds the result; the next word is still taken, but its result waits.
`default_nettype none

module voxel_face_culling_mesher #(
  parameter int MAX_DIM = vfcm_pkg::MAX_DIM_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_func,
  input  wire logic [vfcm_pkg::COORD_W-1:0]   in_row,
  input  wire logic [vfcm_pkg::COORD_W-1:0]   in_column,
  input  wire logic [vfcm_pkg::COORD_W-1:0]   in_slice,
  input  wire logic [vfcm_pkg::VAL_W-1:0]     in_voxel_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_visible,
  output logic [vfcm_pkg::FACES-1:0]          out_face_mask,
  output logic [vfcm_pkg::CNT_W-1:0]          out_base_vertex,
  output logic                                out_coord_error,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [vfcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vfcm_pkg::GRID_W-1:0]    cfg_data
);
  import vfcm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  logic                func_r;
  logic [COORD_W-1:0]  row_r, col_r, slc_r;
  logic [VAL_W-1:0]    val_r;
  logic [GRID_W-1:0]   height_r, width_r, depth_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [VAL_W-1:0]    cur_r, cur_nxt;
  logic [FACES-1:0]    mask_r, mask_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_vis_r, out_vis_nxt;
  logic [FACES-1:0]    out_mask_r, out_mask_nxt;
  logic [CNT_W-1:0]    out_base_r, out_base_nxt;
  logic                out_err_r, out_err_nxt;

  nbr_flags_t          flags;
  logic [AW-1:0]       mem_addr;
  logic                mem_we, mem_re;
  logic [VAL_W-1:0]    mem_rdata_r;
  logic [VAL_W-1:0]    mem [DEPTH];

  logic                in_acc, out_load, vis;
  logic [2:0]          face_idx;

  vfcm_nbr #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_nbr (
    .row         (row_r),
    .column      (col_r),
    .slice       (slc_r),
    .grid_height (height_r),
    .grid_width  (width_r),
    .grid_depth  (depth_r),
    .step        (step_r),
    .flags       (flags),
    .addr        (mem_addr)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_visible     = out_vis_r;
  assign out_face_mask   = out_mask_r;
  assign out_base_vertex = out_base_r;
  assign out_coord_error = out_err_r;

  assign vis      = !flags.err && (func_r == FUNC_MESH) && (cur_r != '0);
  assign face_idx = step_r - 3'd2;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cur_nxt       = cur_r;
    mask_nxt      = mask_r;
    cnt_nxt       = cnt_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_vis_nxt   = out_vis_r;
    out_mask_nxt  = out_mask_r;
    out_base_nxt  = out_base_r;
    out_err_nxt   = out_err_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RUN;
          step_nxt  = STEP_CTR;
        end
      end
      ST_RUN: begin
        if (step_r == STEP_CTR && (flags.err || func_r == FUNC_WRITE)) begin
          mem_we    = !flags.err;
          state_nxt = ST_FIN;
        end else begin
          mem_re   = (step_r != STEP_LAST);
          step_nxt = step_r + 3'd1;
          if (step_r == STEP_LEFT) begin
            cur_nxt = mem_rdata_r;
          end else if (step_r != STEP_CTR) begin
            mask_nxt[face_idx] = flags.edge_hit[face_idx] || (mem_rdata_r != cur_r);
          end
          if (step_r == STEP_LAST) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_vis_nxt   = vis;
          out_mask_nxt  = vis ? mask_r : '0;
          out_base_nxt  = vis ? cnt_r : '0;
          out_err_nxt   = flags.err;
          if (vis) begin
            cnt_nxt = cnt_r + VERTS_PER_VOXEL;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_CTR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      height_r    <= GRID_RESET;
      width_r     <= GRID_RESET;
      depth_r     <= GRID_RESET;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HEIGHT: height_r <= cfg_data;
          REG_WIDTH:  width_r  <= cfg_data;
          REG_DEPTH:  depth_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      row_r  <= in_row;
      col_r  <= in_column;
      slc_r  <= in_slice;
      val_r  <= in_voxel_value;
    end
    cur_r        <= cur_nxt;
    mask_r       <= mask_nxt;
    out_vis_r    <= out_vis_nxt;
    out_mask_r   <= out_mask_nxt;
    out_base_r   <= out_base_nxt;
    out_err_r    <= out_err_nxt;
  end

  // single-port volume; one word in flight, so no access overlaps another word
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= val_r;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_addr];
    end
  end

  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_RUN && step_r == STEP_CTR))
    else $error("accepted word did not start the read sequence");

  a_write_at_center: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_RUN && step_r == STEP_CTR && !mem_re))
    else $error("volume write outside the center step");

  a_visible_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_vis_r && out_err_r))
    else $error("visible result with coordinate error");

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_vis_r) |-> (out_mask_r == '0 && out_base_r == '0))
    else $error("hidden result carries face mask or base vertex");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + VERTS_PER_VOXEL && $past(out_load)))
    else $error("vertex count changed by other than one voxel");

endmodule

`default_nettype wire

// ===== sv/vfcm_nbr.sv =====
// vfcm_nbr: grid range check, boundary faces and volume address per read step.
// Depends on vfcm_pkg.
`default_nettype none

module vfcm_nbr #(
  parameter int MAX_DIM = vfcm_pkg::MAX_DIM_DEF,
  parameter int AW      = $clog2(MAX_DIM * MAX_DIM * MAX_DIM)
) (
  input  wire logic [vfcm_pkg::COORD_W-1:0] row,
  input  wire logic [vfcm_pkg::COORD_W-1:0] column,
  input  wire logic [vfcm_pkg::COORD_W-1:0] slice,
  input  wire logic [vfcm_pkg::GRID_W-1:0]  grid_height,
  input  wire logic [vfcm_pkg::GRID_W-1:0]  grid_width,
  input  wire logic [vfcm_pkg::GRID_W-1:0]  grid_depth,
  input  wire vfcm_pkg::step_t              step,
  output vfcm_pkg::nbr_flags_t              flags,
  output logic [AW-1:0]                     addr
);
  import vfcm_pkg::*;

  localparam logic [8:0] MAXD = 9'(MAX_DIM);

  logic [8:0] r9, c9, s9, h9, w9, d9;
  logic [5:0] nr, nc, ns;

  assign r9 = {4'b0, row};
  assign c9 = {4'b0, column};
  assign s9 = {4'b0, slice};
  assign h9 = {3'b0, grid_height};
  assign w9 = {3'b0, grid_width};
  assign d9 = {3'b0, grid_depth};

  assign flags.err = (r9 >= h9) || (r9 >= MAXD) || (c9 >= w9) || (c9 >= MAXD) ||
                     (s9 >= d9) || (s9 >= MAXD);

  assign flags.edge_hit[FACE_LEFT]  = (column == '0);
  assign flags.edge_hit[FACE_RIGHT] = (c9 + 9'd1 >= w9) || (c9 + 9'd1 >= MAXD);
  assign flags.edge_hit[FACE_TOP]   = (row == '0);
  assign flags.edge_hit[FACE_BOT]   = (r9 + 9'd1 >= h9) || (r9 + 9'd1 >= MAXD);
  assign flags.edge_hit[FACE_FRONT] = (slice == '0);
  assign flags.edge_hit[FACE_REAR]  = (s9 + 9'd1 >= d9) || (s9 + 9'd1 >= MAXD);

  // neighbour coordinates; a face on the grid boundary reads the center instead
  always_comb begin
    nr = {1'b0, row};
    nc = {1'b0, column};
    ns = {1'b0, slice};
    case (step)
      STEP_LEFT:  if (!flags.edge_hit[FACE_LEFT])  nc = {1'b0, column} - 6'd1;
      STEP_RIGHT: if (!flags.edge_hit[FACE_RIGHT]) nc = {1'b0, column} + 6'd1;
      STEP_TOP:   if (!flags.edge_hit[FACE_TOP])   nr = {1'b0, row} - 6'd1;
      STEP_BOT:   if (!flags.edge_hit[FACE_BOT])   nr = {1'b0, row} + 6'd1;
      STEP_FRONT: if (!flags.edge_hit[FACE_FRONT]) ns = {1'b0, slice} - 6'd1;
      STEP_REAR:  if (!flags.edge_hit[FACE_REAR])  ns = {1'b0, slice} + 6'd1;
      default: ;
    endcase
  end

  assign addr = AW'((AW'(nr) * AW'(MAX_DIM) + AW'(nc)) * AW'(MAX_DIM) + AW'(ns));

endmodule

`default_nettype wire

// ===== sim/voxel_face_culling_mesher_test.sv =====
// voxel_face_culling_mesher_test: self-checking bench for the voxel face culling mesher.
// Drives words and grid writes with random idling and checks every result word.
// Depends on vfcm_pkg and voxel_face_culling_mesher.
`default_nettype none

module voxel_face_culling_mesher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vfcm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic             visible;
    logic [FACES-1:0] face_mask;
    logic [CNT_W-1:0] base_vertex;
    logic             coord_error;
  } face_report_t;

  typedef struct {
    bit                   is_cfg;
    logic                 func;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   column;
    logic [COORD_W-1:0]   slice;
    logic [VAL_W-1:0]     value;
    logic [CFG_IDX_W-1:0] idx;
    logic [GRID_W-1:0]    data;
    bit                   typed;
    face_report_t         want;
  } plan_row_t;

  localparam face_report_t NO_FACE   = '0;
  localparam face_report_t BAD_COORD = '{1'b0, 6'd0, 18'd0, 1'b1};

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_func = FUNC_WRITE;
  logic [COORD_W-1:0]   in_row = '0;
  logic [COORD_W-1:0]   in_column = '0;
  logic [COORD_W-1:0]   in_slice = '0;
  logic [VAL_W-1:0]     in_voxel_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_visible;
  logic [FACES-1:0]     out_face_mask;
  logic [CNT_W-1:0]     out_base_vertex;
  logic                 out_coord_error;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GRID_W-1:0]    cfg_data = '0;

  // tag carried alongside each input word
  bit           hold_typed = 1'b0;
  face_report_t hold_want = '0;

  // mesher model
  bit   [VAL_W-1:0]  mdl_vol [0:32767];
  logic [CNT_W-1:0]  mdl_vertices = '0;
  logic [GRID_W-1:0] mdl_rows = GRID_RESET;
  logic [GRID_W-1:0] mdl_cols = GRID_RESET;
  logic [GRID_W-1:0] mdl_slices = GRID_RESET;

  // driver bookkeeping
  bit filled [0:32767];
  int drv_rows = 32;
  int drv_cols = 32;
  int drv_slices = 32;
  bit steady = 1'b0;

  face_report_t pending_reports[$];
  int words_sent = 0;
  int words_done = 0;
  int fail_count = 0;
  int shown = 0;

  plan_row_t plan[$];

  voxel_face_culling_mesher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func), .in_row(in_row),
    .in_column(in_column), .in_slice(in_slice), .in_voxel_value(in_voxel_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_visible(out_visible),
    .out_face_mask(out_face_mask), .out_base_vertex(out_base_vertex),
    .out_coord_error(out_coord_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic int clamp_dim(input logic [GRID_W-1:0] g);
    return (g > GRID_W'(MAX_DIM_DEF)) ? MAX_DIM_DEF : int'(g);
  endfunction

  function automatic face_report_t mesh_word(input logic func, input logic [COORD_W-1:0] r,
                                             input logic [COORD_W-1:0] c,
                                             input logic [COORD_W-1:0] s,
                                             input logic [VAL_W-1:0] v);
    face_report_t rep;
    logic [VAL_W-1:0] cur;
    int h, w, d, ri, ci, si;
    h = clamp_dim(mdl_rows);
    w = clamp_dim(mdl_cols);
    d = clamp_dim(mdl_slices);
    ri = r;
    ci = c;
    si = s;
    rep = '0;
    if (ri >= h || ci >= w || si >= d) begin
      rep.coord_error = 1'b1;
    end else if (func == FUNC_WRITE) begin
      mdl_vol[{r, c, s}] = v;
    end else begin
      cur = mdl_vol[{r, c, s}];
      if (cur != '0) begin
        rep.visible = 1'b1;
        rep.base_vertex = mdl_vertices;
        mdl_vertices = mdl_vertices + VERTS_PER_VOXEL;
        if (ci == 0 || mdl_vol[{r, c - 5'd1, s}] != cur) rep.face_mask[FACE_LEFT] = 1'b1;
        if (ci + 1 >= w || mdl_vol[{r, c + 5'd1, s}] != cur) rep.face_mask[FACE_RIGHT] = 1'b1;
        if (ri == 0 || mdl_vol[{r - 5'd1, c, s}] != cur) rep.face_mask[FACE_TOP] = 1'b1;
        if (ri + 1 >= h || mdl_vol[{r + 5'd1, c, s}] != cur) rep.face_mask[FACE_BOT] = 1'b1;
        if (si == 0 || mdl_vol[{r, c, s - 5'd1}] != cur) rep.face_mask[FACE_FRONT] = 1'b1;
        if (si + 1 >= d || mdl_vol[{r, c, s + 5'd1}] != cur) rep.face_mask[FACE_REAR] = 1'b1;
      end
    end
    return rep;
  endfunction

  always @(posedge clk) begin : watch
    face_report_t want;
    face_report_t rep;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HEIGHT: mdl_rows = cfg_data;
          REG_WIDTH:  mdl_cols = cfg_data;
          REG_DEPTH:  mdl_slices = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        rep = mesh_word(in_func, in_row, in_column, in_slice, in_voxel_value);
        pending_reports.push_back(hold_typed ? hold_want : rep);
      end
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("unexpected word: vis=%0d mask=%b base=%0d err=%0d",
                     out_visible, out_face_mask, out_base_vertex, out_coord_error);
          end
        end else begin
          want = pending_reports.pop_front();
          words_done++;
          if (out_visible !== want.visible || out_face_mask !== want.face_mask ||
              out_base_vertex !== want.base_vertex || out_coord_error !== want.coord_error) begin
            fail_count++;
            if (shown < 10) begin
              shown++;
              $display({"mismatch: exp vis=%0d mask=%b base=%0d err=%0d, ",
                        "got vis=%0d mask=%b base=%0d err=%0d"},
                       want.visible, want.face_mask, want.base_vertex, want.coord_error,
                       out_visible, out_face_mask, out_base_vertex, out_coord_error);
            end
          end
        end
      end
    end
  end

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : sink
    int stall;
    @(posedge clk);
    forever begin
      if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  function automatic logic [VAL_W-1:0] palette();
    case ($urandom_range(0, 9))
      0:             return 8'h00;
      1, 2, 3, 4, 5: return 8'h3C;
      6, 7:          return 8'hC3;
      8:             return 8'hFF;
      default:       return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [GRID_W-1:0] pick_grid();
    case ($urandom_range(0, 19))
      0:       return 6'd0;
      1, 2:    return 6'($urandom_range(33, 63));
      3, 4, 5: return 6'd32;
      6, 7:    return 6'd1;
      default: return 6'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(input int dim, input int lo);
    int v;
    if (dim == 0) return 5'($urandom_range(0, 31));
    case ($urandom_range(0, 4))
      0: v = 0;
      1: v = dim - 1;
      default: begin
        v = lo + $urandom_range(0, 3);
        if (v > dim - 1) v = dim - 1;
      end
    endcase
    return 5'(v);
  endfunction

  function automatic bit in_drv_grid(input int r, input int c, input int s);
    return r >= 0 && c >= 0 && s >= 0 && r < drv_rows && c < drv_cols && s < drv_slices;
  endfunction

  task automatic send_word(input logic func, input logic [COORD_W-1:0] r,
                           input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] s,
                           input logic [VAL_W-1:0] v, input bit typed = 1'b0,
                           input face_report_t want = '0);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (cfg_valid) cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_row <= r;
    in_column <= c;
    in_slice <= s;
    in_voxel_value <= v;
    hold_typed <= typed;
    hold_want <= want;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (func == FUNC_WRITE && in_drv_grid(r, c, s)) filled[{r, c, s}] = 1'b1;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [GRID_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HEIGHT: drv_rows = clamp_dim(data);
      REG_WIDTH:  drv_cols = clamp_dim(data);
      REG_DEPTH:  drv_slices = clamp_dim(data);
      default: ;
    endcase
  endtask

  // wait until every accepted word has produced its result
  task automatic settle();
    in_valid <= 1'b0;
    while (words_done != words_sent) @(posedge clk);
  endtask

  task automatic prime_cell(input int r, input int c, input int s);
    if (in_drv_grid(r, c, s) && !filled[r * 1024 + c * 32 + s])
      send_word(FUNC_WRITE, 5'(r), 5'(c), 5'(s), palette());
  endtask

  // voxel and in-grid neighbours are written before any mesh read
  task automatic mesh_at(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                         input logic [COORD_W-1:0] s, input logic [VAL_W-1:0] v,
                         input bit typed = 1'b0, input face_report_t want = '0);
    int ri, ci, si;
    ri = r;
    ci = c;
    si = s;
    if (in_drv_grid(ri, ci, si)) begin
      prime_cell(ri, ci, si);
      prime_cell(ri, ci - 1, si);
      prime_cell(ri, ci + 1, si);
      prime_cell(ri - 1, ci, si);
      prime_cell(ri + 1, ci, si);
      prime_cell(ri, ci, si - 1);
      prime_cell(ri, ci, si + 1);
    end
    send_word(FUNC_MESH, r, c, s, v, typed, want);
  endtask

  function automatic plan_row_t row_word(input logic func, input int r, input int c,
                                         input int s, input logic [VAL_W-1:0] v,
                                         input bit typed = 1'b0,
                                         input face_report_t want = '0);
    plan_row_t p;
    p = '{default: '0};
    p.func = func;
    p.row = 5'(r);
    p.column = 5'(c);
    p.slice = 5'(s);
    p.value = v;
    p.typed = typed;
    p.want = want;
    return p;
  endfunction

  function automatic plan_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [GRID_W-1:0] data);
    plan_row_t p;
    p = '{default: '0};
    p.is_cfg = 1'b1;
    p.idx = idx;
    p.data = data;
    return p;
  endfunction

  initial begin : stim
    int ph, start, k, lo_r, lo_c, lo_s;
    logic [COORD_W-1:0] r, c, s;

    plan.push_back(row_word(FUNC_WRITE, 0, 0, 0, 8'hFF, 1, NO_FACE));
    plan.push_back(row_word(FUNC_WRITE, 0, 1, 0, 8'hFF, 1, NO_FACE));
    plan.push_back(row_word(FUNC_WRITE, 1, 0, 0, 8'h01, 1, NO_FACE));
    plan.push_back(row_word(FUNC_WRITE, 0, 0, 1, 8'h00, 1, NO_FACE));
    plan.push_back(row_word(FUNC_MESH, 0, 0, 0, 8'hAA, 1, '{1'b1, 6'b111101, 18'd0, 1'b0}));
    plan.push_back(row_word(FUNC_WRITE, 31, 31, 31, 8'h80, 1, NO_FACE));
    plan.push_back(row_word(FUNC_WRITE, 30, 31, 31, 8'h80, 1, NO_FACE));
    plan.push_back(row_word(FUNC_WRITE, 31, 30, 31, 8'h7F, 1, NO_FACE));
    plan.push_back(row_word(FUNC_WRITE, 31, 31, 30, 8'h7F, 1, NO_FACE));
    plan.push_back(row_word(FUNC_MESH, 31, 31, 31, 8'h55));
    // zero voxel
    plan.push_back(row_word(FUNC_MESH, 0, 0, 1, 8'h00, 1, NO_FACE));
    plan.push_back(row_cfg(REG_HEIGHT, 6'd4));
    plan.push_back(row_cfg(REG_WIDTH, 6'd5));
    plan.push_back(row_cfg(REG_DEPTH, 6'd3));
    plan.push_back(row_word(FUNC_WRITE, 4, 0, 0, 8'h11, 1, BAD_COORD));
    plan.push_back(row_word(FUNC_MESH, 0, 5, 0, 8'h00, 1, BAD_COORD));
    plan.push_back(row_word(FUNC_MESH, 0, 0, 3, 8'h00, 1, BAD_COORD));
    plan.push_back(row_word(FUNC_WRITE, 3, 4, 2, 8'h55, 1, NO_FACE));
    plan.push_back(row_word(FUNC_MESH, 3, 4, 2, 8'h00));
    // zero grid
    plan.push_back(row_cfg(REG_HEIGHT, 6'd0));
    plan.push_back(row_word(FUNC_WRITE, 0, 0, 0, 8'h00, 1, BAD_COORD));
    plan.push_back(row_word(FUNC_MESH, 0, 0, 0, 8'h00, 1, BAD_COORD));
    // oversized grid clamps to full size
    plan.push_back(row_cfg(REG_HEIGHT, 6'd63));
    plan.push_back(row_cfg(REG_WIDTH, 6'd40));
    plan.push_back(row_cfg(REG_DEPTH, 6'd33));
    plan.push_back(row_word(FUNC_MESH, 31, 31, 31, 8'hFF));
    plan.push_back(row_cfg(REG_SPARE, 6'h2A));
    plan.push_back(row_cfg(REG_HEIGHT, 6'd1));
    plan.push_back(row_cfg(REG_WIDTH, 6'd1));
    plan.push_back(row_cfg(REG_DEPTH, 6'd1));
    plan.push_back(row_word(FUNC_MESH, 0, 0, 0, 8'h00));
    plan.push_back(row_cfg(REG_HEIGHT, 6'd32));
    plan.push_back(row_cfg(REG_WIDTH, 6'd32));
    plan.push_back(row_cfg(REG_DEPTH, 6'd32));
    plan.push_back(row_word(FUNC_MESH, 0, 0, 0, 8'h00));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        cfg_write(plan[i].idx, plan[i].data);
      end else if (plan[i].func == FUNC_MESH) begin
        mesh_at(plan[i].row, plan[i].column, plan[i].slice, plan[i].value,
                plan[i].typed, plan[i].want);
      end else begin
        send_word(FUNC_WRITE, plan[i].row, plan[i].column, plan[i].slice, plan[i].value,
                  plan[i].typed, plan[i].want);
      end
    end

    // back-to-back mesh words on one voxel
    steady = 1'b1;
    repeat (40) mesh_at(5'd0, 5'd0, 5'd0, 8'($urandom));
    steady = 1'b0;

    for (ph = 0; ph < 8; ph++) begin
      settle();
      cfg_write(REG_HEIGHT, pick_grid());
      cfg_write(REG_WIDTH, pick_grid());
      cfg_write(REG_DEPTH, pick_grid());
      if ($urandom_range(0, 3) == 0) cfg_write(REG_SPARE, 6'($urandom_range(0, 63)));
      lo_r = (drv_rows > 0) ? $urandom_range(0, drv_rows - 1) : 0;
      lo_c = (drv_cols > 0) ? $urandom_range(0, drv_cols - 1) : 0;
      lo_s = (drv_slices > 0) ? $urandom_range(0, drv_slices - 1) : 0;
      start = words_sent;
      while (words_sent - start < 175) begin
        k = $urandom_range(0, 99);
        if (k < 55) begin
          r = pick_coord(drv_rows, lo_r);
          c = pick_coord(drv_cols, lo_c);
          s = pick_coord(drv_slices, lo_s);
          if ($urandom_range(0, 2) == 0) send_word(FUNC_WRITE, r, c, s, palette());
          mesh_at(r, c, s, 8'($urandom));
        end else if (k < 80) begin
          send_word(FUNC_WRITE, pick_coord(drv_rows, lo_r), pick_coord(drv_cols, lo_c),
                    pick_coord(drv_slices, lo_s), palette());
        end else if (k < 90) begin
          send_word(FUNC_WRITE, 5'($urandom), 5'($urandom), 5'($urandom), 8'($urandom));
        end else begin
          mesh_at(5'($urandom), 5'($urandom), 5'($urandom), 8'($urandom));
        end
      end
    end

    settle();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
